// ===== hw/rtl/sbpa_pkg.sv =====
// Shared types and constants of the score-based predictor arbiter.
package sbpa_pkg;

	// Request and result field widths
	localparam int unsigned MODE_W = 2;
	localparam int unsigned SEQ_W = 64;
	localparam int unsigned MASK_BITS = 4;
	localparam int unsigned CHOICE_OUT_W = 2;

	// In-flight table geometry (slot is the low sequence bits)
	localparam int unsigned INFLIGHT_DEPTH = 64;
	localparam int unsigned SLOT_W = $clog2(INFLIGHT_DEPTH);

	// Request modes
	localparam logic [MODE_W-1:0] MODE_PREDICT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SQUASH = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SEQ_W-1:0] seq_no;
		logic [MASK_BITS-1:0] valid_mask;
		logic mispredicted;
	} item_t;

	typedef struct packed {
		logic chosen_found;
		logic [CHOICE_OUT_W-1:0] chosen_index;
		logic penalty_to_chosen;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED_SCAN,
		ST_PRED_WRITE,
		ST_CMT_READ,
		ST_CMT_CHECK,
		ST_SQ_WALK,
		ST_SQ_DRAIN
	} state_t;

endpackage

// ===== hw/rtl/score_based_predictor_arbiter.sv =====
// Top level of the score-based predictor arbiter with its in-flight choice table.
//
// Usage: a request is taken on a rising edge with start high and busy low. Its mode
// selects predict, commit or squash. Exactly one result follows for every request:
// done is high for one cycle with result valid in that cycle; the receiver cannot
// stall it, and the next request may be taken while done is high.
// Steps after the accepting edge; the one shared score comparator serves predict:
//   predict: each predictor scored once, one per cycle, round-robin from the slot
//            after the last choice in dynamic mode, else from predictor 0, then the table write.
//   commit:  table read, then tag check and score update.
//   squash:  one table entry tag-compared per cycle through the RAM read port, then
//            a drain state for the last check.
//   mode 3:  no steps; an all-zero result follows.
// done rises in the first cycle with busy low (the cycle after accept for mode 3), so
// no new request is taken before the last one has finished its steps.
// The dynamic_arbitration register is written through cfg_valid/cfg_data and is
// always ready; write it only while idle.
// Reset: scores go to half of maximum, the last choice to the top predictor, all
// table entries invalid and dynamic arbitration on; no clearing pass is needed.
module score_based_predictor_arbiter #(
	parameter int unsigned NUM_PREDICTORS = 4,
	parameter int unsigned SCORE_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sbpa_pkg::item_t    item,
	output logic               done,
	output sbpa_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	localparam int unsigned IDX_W = (NUM_PREDICTORS > 1) ? $clog2(NUM_PREDICTORS) : 1;
	localparam int unsigned RAM_W = sbpa_pkg::SEQ_W + IDX_W;
	localparam int unsigned DEPTH = sbpa_pkg::INFLIGHT_DEPTH;
	localparam int unsigned SLOT_W = sbpa_pkg::SLOT_W;
	localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};
	localparam logic [SCORE_BITS-1:0] SCORE_INIT = SCORE_MAX >> 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PREDICTORS - 1);

	sbpa_pkg::state_t state_q, state_d;

	sbpa_pkg::item_t         item_q;
	logic [NUM_PREDICTORS-1:0] offered_q;
	logic [NUM_PREDICTORS-1:0] offered_in;
	logic [IDX_W-1:0]        idx_q, start_idx_q, idx_next, rr_start;
	logic                    found_q;
	logic [SCORE_BITS-1:0]   best_q;
	logic [IDX_W-1:0]        pick_q;
	logic [IDX_W-1:0]        last_q;
	logic [SCORE_BITS-1:0]   scores_q [NUM_PREDICTORS];
	logic [DEPTH-1:0]        valid_q;
	logic                    dyn_q;
	logic [SLOT_W-1:0]       walk_q;
	logic                    chk_vld_s1;
	logic [SLOT_W-1:0]       chk_addr_s1;
	logic                    done_q;
	sbpa_pkg::result_t       result_q;

	logic                    accept;
	logic [SLOT_W-1:0]       slot;
	logic                    ram_we;
	logic [SLOT_W-1:0]       ram_raddr;
	logic [RAM_W-1:0]        ram_wdata, ram_rdata;
	logic [sbpa_pkg::SEQ_W-1:0] rd_tag;
	logic [IDX_W-1:0]        rd_choice;
	logic                    cmt_hit;
	logic                    take;
	logic [SCORE_BITS-1:0]   cur_score;
	logic [SCORE_BITS-1:0]   trained;

	assign accept = start && !busy;
	assign busy = (state_q != sbpa_pkg::ST_IDLE);
	assign done = done_q;
	assign result = result_q;
	assign cfg_ready = 1'b1;
	assign slot = item_q.seq_no[SLOT_W-1:0];

	// Drop mask bits beyond the predictor count
	for (genvar g = 0; g < NUM_PREDICTORS; g++) begin : g_offer
		if (g < sbpa_pkg::MASK_BITS) begin : g_in
			assign offered_in[g] = item.valid_mask[g];
		end else begin : g_none
			assign offered_in[g] = 1'b0;
		end
	end

	// Round-robin stepping
	assign idx_next = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
	assign rr_start = (last_q == IDX_LAST) ? '0 : last_q + 1'b1;

	// Shared score comparator: take the first offered, or, in dynamic mode, a strictly higher score
	assign cur_score = scores_q[idx_q];
	assign take = offered_q[idx_q] && (!found_q || (dyn_q && (cur_score > best_q)));

	// Table read data
	assign rd_tag = ram_rdata[RAM_W-1:IDX_W];
	assign rd_choice = ram_rdata[IDX_W-1:0];
	assign cmt_hit = valid_q[slot] && (rd_tag == item_q.seq_no);
	assign ram_wdata = {item_q.seq_no, pick_q};

	// Saturating score training of the committed choice
	always_comb begin
		trained = scores_q[rd_choice];
		if (item_q.mispredicted) begin
			if (trained != '0) begin
				trained = trained - 1'b1;
			end
		end else if (trained != SCORE_MAX) begin
			trained = trained + 1'b1;
		end
	end

	sbpa_ram #(
		.WIDTH(RAM_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence next state and table port controls
	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_raddr = slot;
		unique case (state_q)
			sbpa_pkg::ST_IDLE: begin
				if (accept) begin
					case (item.mode)
						sbpa_pkg::MODE_PREDICT: state_d = sbpa_pkg::ST_PRED_SCAN;
						sbpa_pkg::MODE_COMMIT:  state_d = sbpa_pkg::ST_CMT_READ;
						sbpa_pkg::MODE_SQUASH:  state_d = sbpa_pkg::ST_SQ_WALK;
						default:                state_d = sbpa_pkg::ST_IDLE;
					endcase
				end
			end
			sbpa_pkg::ST_PRED_SCAN: begin
				if (idx_next == start_idx_q) begin
					state_d = sbpa_pkg::ST_PRED_WRITE;
				end
			end
			sbpa_pkg::ST_PRED_WRITE: begin
				ram_we = found_q;
				state_d = sbpa_pkg::ST_IDLE;
			end
			sbpa_pkg::ST_CMT_READ: begin
				state_d = sbpa_pkg::ST_CMT_CHECK;
			end
			sbpa_pkg::ST_CMT_CHECK: begin
				state_d = sbpa_pkg::ST_IDLE;
			end
			sbpa_pkg::ST_SQ_WALK: begin
				ram_raddr = walk_q;
				if (walk_q == SLOT_W'(DEPTH - 1)) begin
					state_d = sbpa_pkg::ST_SQ_DRAIN;
				end
			end
			sbpa_pkg::ST_SQ_DRAIN: begin
				state_d = sbpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = sbpa_pkg::ST_IDLE;
			end
		endcase
	end

	// Raise done, scan predictors, train scores, take mode writes and update valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PREDICTORS; i++) begin
				scores_q[i] <= SCORE_INIT;
			end
			last_q <= IDX_LAST;
			valid_q <= '0;
			dyn_q <= 1'b1;
			done_q <= 1'b0;
			chk_vld_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			chk_vld_s1 <= (state_q == sbpa_pkg::ST_SQ_WALK);

			if (cfg_valid && cfg_ready) begin
				dyn_q <= cfg_data;
			end

			// Squash check stage: drop valid entries younger than the kept number
			if (chk_vld_s1 && valid_q[chk_addr_s1] && (rd_tag > item_q.seq_no)) begin
				valid_q[chk_addr_s1] <= 1'b0;
			end

			case (state_q)
				sbpa_pkg::ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if (item.mode != sbpa_pkg::MODE_PREDICT &&
						    item.mode != sbpa_pkg::MODE_COMMIT &&
						    item.mode != sbpa_pkg::MODE_SQUASH) begin
							done_q <= 1'b1;
						end
					end
				end
				sbpa_pkg::ST_PRED_SCAN: begin
					if (take) begin
						found_q <= 1'b1;
					end
				end
				sbpa_pkg::ST_PRED_WRITE: begin
					valid_q[slot] <= found_q;
					if (found_q) begin
						last_q <= pick_q;
					end
					done_q <= 1'b1;
				end
				sbpa_pkg::ST_CMT_CHECK: begin
					if (cmt_hit) begin
						valid_q[slot] <= 1'b0;
						if (dyn_q && ({1'b0, rd_choice} < (IDX_W + 1)'(NUM_PREDICTORS))) begin
							scores_q[rd_choice] <= trained;
						end
					end
					done_q <= 1'b1;
				end
				sbpa_pkg::ST_SQ_DRAIN: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: request copy, scan cursor, walk address, result
	always_ff @(posedge clk) begin
		chk_addr_s1 <= walk_q;
		case (state_q)
			sbpa_pkg::ST_IDLE: begin
				if (accept) begin
					item_q <= item;
					offered_q <= offered_in;
					best_q <= '0;
					pick_q <= '0;
					idx_q <= dyn_q ? rr_start : '0;
					start_idx_q <= dyn_q ? rr_start : '0;
					walk_q <= '0;
					result_q <= '0;
				end
			end
			sbpa_pkg::ST_PRED_SCAN: begin
				if (take) begin
					best_q <= cur_score;
					pick_q <= idx_q;
				end
				idx_q <= idx_next;
			end
			sbpa_pkg::ST_PRED_WRITE: begin
				result_q.chosen_found <= found_q;
				result_q.chosen_index <= found_q ? sbpa_pkg::CHOICE_OUT_W'(pick_q) : '0;
				result_q.penalty_to_chosen <= 1'b0;
			end
			sbpa_pkg::ST_CMT_CHECK: begin
				result_q.chosen_found <= cmt_hit;
				result_q.chosen_index <= cmt_hit ? sbpa_pkg::CHOICE_OUT_W'(rd_choice) : '0;
				result_q.penalty_to_chosen <= cmt_hit && item_q.mispredicted;
			end
			sbpa_pkg::ST_SQ_WALK: begin
				walk_q <= walk_q + 1'b1;
			end
			sbpa_pkg::ST_SQ_DRAIN: begin
				result_q <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/sbpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbpa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== test/score_based_predictor_arbiter_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the arbiter's choices and compares every result it reports.
module score_based_predictor_arbiter_checker
	import sbpa_pkg::*;
#(
	parameter int unsigned NUM_PREDICTORS = 4,
	parameter int unsigned SCORE_BITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        done,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int unsigned pending,
	output int unsigned failures
);

	localparam logic [SCORE_BITS-1:0] SCORE_TOP = '1;
	localparam int unsigned NONE_PICKED = NUM_PREDICTORS;

	// Shadow copy of the arbiter state
	logic [SCORE_BITS-1:0] score_tab [NUM_PREDICTORS];
	int unsigned last_pick;
	bit slot_live [INFLIGHT_DEPTH];
	int unsigned slot_pick [INFLIGHT_DEPTH];
	logic [SEQ_W-1:0] slot_seq [INFLIGHT_DEPTH];
	bit dyn_arb;

	result_t expected_choices [$];
	result_t want;

	task automatic report(string what, logic [63:0] want_v, logic [63:0] got_v);
		$display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
		failures++;
	endtask

	// Lowest offered predictor, or best score with round-robin ties after the last pick
	function automatic int unsigned pick_predictor(logic [MASK_BITS-1:0] offered);
		int unsigned count;
		int unsigned first;
		int unsigned cand;
		logic [SCORE_BITS-1:0] best;
		logic [NUM_PREDICTORS-1:0] ties;
		count = 0;
		first = NONE_PICKED;
		best = '0;
		ties = '0;
		for (int i = 0; i < NUM_PREDICTORS && i < MASK_BITS; i++) begin
			if (offered[i]) begin
				if (count == 0)
					first = i;
				count++;
				if (score_tab[i] > best)
					best = score_tab[i];
			end
		end
		if (count <= 1 || !dyn_arb)
			return first;
		for (int i = 0; i < NUM_PREDICTORS && i < MASK_BITS; i++)
			if (offered[i] && score_tab[i] == best)
				ties[i] = 1'b1;
		for (int step = 1; step <= NUM_PREDICTORS; step++) begin
			cand = (last_pick + step) % NUM_PREDICTORS;
			if (ties[cand])
				return cand;
		end
		return first;
	endfunction

	// Apply one request to the shadow state and return its result
	function automatic result_t arbitrate(item_t req);
		result_t res;
		int unsigned slot;
		int unsigned c;
		res = '0;
		slot = int'(req.seq_no[SLOT_W-1:0]);
		case (req.mode)
			MODE_PREDICT: begin
				c = pick_predictor(req.valid_mask);
				if (c == NONE_PICKED) begin
					slot_live[slot] = 1'b0;
				end else begin
					slot_live[slot] = 1'b1;
					slot_seq[slot] = req.seq_no;
					slot_pick[slot] = c;
					last_pick = c;
					res.chosen_found = 1'b1;
					res.chosen_index = c[CHOICE_OUT_W-1:0];
				end
			end
			MODE_COMMIT: begin
				if (slot_live[slot] && slot_seq[slot] == req.seq_no) begin
					c = slot_pick[slot];
					// train the chosen score, saturating at both ends
					if (dyn_arb) begin
						if (req.mispredicted) begin
							if (score_tab[c] != '0)
								score_tab[c]--;
						end else if (score_tab[c] != SCORE_TOP) begin
							score_tab[c]++;
						end
					end
					slot_live[slot] = 1'b0;
					res.chosen_found = 1'b1;
					res.chosen_index = c[CHOICE_OUT_W-1:0];
					res.penalty_to_chosen = req.mispredicted;
				end
			end
			MODE_SQUASH: begin
				for (int i = 0; i < INFLIGHT_DEPTH; i++)
					if (slot_live[i] && slot_seq[i] > req.seq_no)
						slot_live[i] = 1'b0;
			end
			default: ;
		endcase
		return res;
	endfunction

	// Compare results against the oldest expectation, then log new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PREDICTORS; i++)
				score_tab[i] = SCORE_TOP >> 1;
			last_pick = NUM_PREDICTORS - 1;
			for (int i = 0; i < INFLIGHT_DEPTH; i++)
				slot_live[i] = 1'b0;
			dyn_arb = 1'b1;
			expected_choices.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_choices.size() == 0) begin
					report("unexpected result", 64'(0), 64'(result));
				end else begin
					want = expected_choices.pop_front();
					if (result.chosen_found !== want.chosen_found)
						report("chosen_found", 64'(want.chosen_found),
							64'(result.chosen_found));
					if (result.chosen_index !== want.chosen_index)
						report("chosen_index", 64'(want.chosen_index),
							64'(result.chosen_index));
					if (result.penalty_to_chosen !== want.penalty_to_chosen)
						report("penalty_to_chosen", 64'(want.penalty_to_chosen),
							64'(result.penalty_to_chosen));
				end
			end
			if (cfg_valid && cfg_ready)
				dyn_arb = cfg_data;
			// Append the predicted result of a taken request
			if (start && !busy)
				expected_choices = {expected_choices, arbitrate(item)};
			pending <= expected_choices.size();
		end
	end

endmodule

// ===== test/score_based_predictor_arbiter_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives requests and mode writes into the arbiter and gives the verdict.
module score_based_predictor_arbiter_test;
	import sbpa_pkg::*;

	localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = INFLIGHT_DEPTH + 8;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam int unsigned NUM_PHASES = 5;
	// arbitration mode per phase, phase 0 in bit 0
	localparam logic [NUM_PHASES-1:0] PHASE_DYN = 5'b01101;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t req;
	logic done;
	result_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	int unsigned pending;
	int unsigned failures;
	int unsigned cycles = 0;
	int unsigned sent;
	int unsigned miss_pct;
	bit steady;

	score_based_predictor_arbiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(req),
		.done(done),
		.result(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	score_based_predictor_arbiter_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(req),
		.done(done),
		.result(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.pending(pending),
		.failures(failures)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** score_based_predictor_arbiter: FAILED **");
			$finish;
		end
	end

	function automatic logic [SEQ_W-1:0] rand_seq();
		return {$urandom, $urandom};
	endfunction

	// Offer one request, idling at random cycles before it unless steady, and hold it until taken
	task automatic send(logic [MODE_W-1:0] mode, logic [SEQ_W-1:0] seq,
			logic [MASK_BITS-1:0] mask, logic miss);
		while (!steady && $urandom_range(99) < 23) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= '{mode: mode, seq_no: seq, valid_mask: mask, mispredicted: miss};
		do @(posedge clk); while (busy);
		if (mode != MODE_RESERVED)
			sent++;
	endtask

	// Hold off until every outstanding request has reported
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_mode(logic dyn);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= dyn;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Predict a run of consecutive sequence numbers, maybe squash, then commit them
	task automatic window();
		logic [SEQ_W-1:0] base;
		int unsigned n;
		int unsigned sel;
		logic [MASK_BITS-1:0] mask;
		base = rand_seq();
		sel = $urandom_range(0, 9);
		if (sel == 0)
			base[SEQ_W-1:4] = '1;
		else if (sel == 1)
			base[SEQ_W-1:4] = '0;
		n = $urandom_range(1, 6);
		for (int k = 0; k < n; k++) begin
			mask = ($urandom_range(0, 9) == 0) ? '0 : MASK_BITS'($urandom_range(1, 15));
			send(MODE_PREDICT, base + k, mask, 1'($urandom));
		end
		if ($urandom_range(0, 6) == 0)
			send(MODE_SQUASH, base + $urandom_range(0, n - 1), MASK_BITS'($urandom),
				1'($urandom));
		for (int k = 0; k < n; k++)
			if ($urandom_range(0, 9) != 0)
				send(MODE_COMMIT, base + k, MASK_BITS'($urandom),
					$urandom_range(99) < miss_pct);
	endtask

	// Stray request: reserved mode, stale commit, lone predict or wide squash
	task automatic noise();
		case ($urandom_range(0, 3))
			0: send(MODE_RESERVED, rand_seq(), MASK_BITS'($urandom), 1'($urandom));
			1: send(MODE_COMMIT, rand_seq(), MASK_BITS'($urandom), 1'($urandom));
			2: send(MODE_PREDICT, rand_seq(), MASK_BITS'($urandom), 1'($urandom));
			default: send(MODE_SQUASH, rand_seq(), MASK_BITS'($urandom), 1'($urandom));
		endcase
	endtask

	initial begin
		logic [SEQ_W-1:0] seq;
		int unsigned goal;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		req = '0;
		arst_n = 1'b0;
		steady = 1'b0;
		miss_pct = 50;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Write every table slot once so no later lookup sees an unwritten entry
		for (int s = 0; s < INFLIGHT_DEPTH; s++) begin
			seq = rand_seq();
			seq[SLOT_W-1:0] = SLOT_W'(s);
			send(MODE_PREDICT, seq, MASK_BITS'($urandom_range(1, 15)), 1'($urandom));
		end

		// Directed: empty mask, commit miss, ties, extremes, aliasing, squash, reserved mode
		send(MODE_PREDICT, '0, '0, 1'b1);
		send(MODE_COMMIT, '0, '1, 1'b0);
		send(MODE_PREDICT, '1, '1, 1'b0);
		send(MODE_PREDICT, '1 - 1, '1, 1'b1);
		send(MODE_PREDICT, 64'd2, '1, 1'b0);
		send(MODE_COMMIT, '1, '0, 1'b1);
		send(MODE_COMMIT, '1, '0, 1'b1);
		send(MODE_COMMIT, '1 - 1, '0, 1'b0);
		send(MODE_COMMIT, 64'd2, '0, 1'b0);
		send(MODE_PREDICT, 64'd5, 4'b1000, 1'b0);
		send(MODE_PREDICT, 64'd5 + INFLIGHT_DEPTH, 4'b0001, 1'b0);
		send(MODE_COMMIT, 64'd5, '0, 1'b0);
		send(MODE_COMMIT, 64'd5 + INFLIGHT_DEPTH, '0, 1'b1);
		send(MODE_PREDICT, 64'd100, 4'b0010, 1'b0);
		send(MODE_PREDICT, 64'd101, 4'b0100, 1'b0);
		send(MODE_PREDICT, 64'd102, 4'b0110, 1'b0);
		send(MODE_SQUASH, 64'd100, '1, 1'b1);
		send(MODE_COMMIT, 64'd101, '0, 1'b0);
		send(MODE_COMMIT, 64'd100, '0, 1'b0);
		send(MODE_RESERVED, '1, '1, 1'b1);
		send(MODE_SQUASH, '1, '0, 1'b0);
		send(MODE_SQUASH, '0, '0, 1'b0);
		send(MODE_COMMIT, 64'd102, '0, 1'b0);

		// Random phases: mode, misprediction rate and idling change between them
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_mode(PHASE_DYN[p]);
			case (p)
				0: miss_pct = 8;
				1: miss_pct = 50;
				2, 3: miss_pct = 95;
				default: miss_pct = $urandom_range(20, 80);
			endcase
			steady = (p == 2);
			goal = sent + PHASE_ITEMS;
			while (sent < goal) begin
				if ($urandom_range(0, 9) == 0)
					noise();
				else
					window();
				if (p == 3 && $urandom_range(0, 19) == 0)
					drain();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("** score_based_predictor_arbiter: PASSED **");
		else
			$display("** score_based_predictor_arbiter: FAILED **");
		$finish;
	end

endmodule
